// File: rtl/conv3_pkg.sv
// Shared constants for the 3x3 multichannel convolution unit with ReLU.
package conv3_pkg;

    localparam int PixelDepth  = 2048;
    localparam int WeightDepth = 1024;
    localparam int BiasDepth   = 16;
    localparam int DataWidth   = 16;

    localparam int PixAw  = $clog2(PixelDepth);
    localparam int WtAw   = $clog2(WeightDepth);
    localparam int BiasAw = $clog2(BiasDepth);

    localparam int AddrWidth = 11;
    localparam int SizeWidth = 6;
    localparam int CinWidth  = 4;
    localparam int AccWidth  = 40;
    localparam int QWidth    = 15;
    localparam int PidxWidth = 15;
    localparam int WidxWidth = 11;
    localparam int TapWidth  = 7;
    localparam int PlaneWidth = 12;

    localparam logic [CinWidth-1:0]  MaxCin = 4'd8;
    localparam logic [SizeWidth-1:0] KSize  = 6'd3;
    localparam logic [QWidth-1:0]    QMax   = 15'h7fff;

    localparam logic [1:0] CMD_WEIGHT  = 2'd0;
    localparam logic [1:0] CMD_BIAS    = 2'd1;
    localparam logic [1:0] CMD_PIXEL   = 2'd2;
    localparam logic [1:0] CMD_COMPUTE = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_RANGE = 2'd1;
    localparam logic [1:0] STAT_SAT   = 2'd2;

    localparam logic [1:0] CFG_IMAGE_SIZE  = 2'd0;
    localparam logic [1:0] CFG_CHANNELS_IN = 2'd1;

endpackage

// File: rtl/conv3x3_multichannel_relu_unit.sv
// Top level: 3x3 valid convolution with bias and ReLU over Q8.8 stores, one shared MAC.
// Write beats (kernel, bias, pixel) leave the unit idle. A compute beat walks
// channels_in x 9 taps through the pixel and weight memories, one tap per cycle,
// into a single multiply-accumulate: an in-range request holds the input side
// through setup, run, drain and finish (channels_in saturated at 8; run is skipped
// when it is zero), an out-of-range request through finish only. The tap rate is
// bound by the single read port of each memory feeding the shared MAC. The result
// sits in an output register, so the next beat is accepted while it waits. Memories
// are not cleared after reset; reading an entry never written returns arbitrary data.
module conv3x3_multichannel_relu_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wr_en,
    input  logic [1:0]                           i_cfg_index,
    input  logic [conv3_pkg::SizeWidth-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_cmd,
    input  logic [conv3_pkg::AddrWidth-1:0]      i_addr,
    input  logic signed [conv3_pkg::DataWidth-1:0] i_value,
    input  logic [3:0]                           i_out_channel,
    input  logic [4:0]                           i_out_row,
    input  logic [4:0]                           i_out_col,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [conv3_pkg::QWidth-1:0]         o_conv_value,
    output logic [1:0]                           o_status
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SETUP  = 3'd1;
    localparam logic [2:0] S_RUN    = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    localparam int DW = conv3_pkg::DataWidth;
    localparam int AW = conv3_pkg::AccWidth;

    logic signed [DW-1:0] pix_mem  [conv3_pkg::PixelDepth];
    logic signed [DW-1:0] wt_mem   [conv3_pkg::WeightDepth];
    logic signed [DW-1:0] bias_mem [conv3_pkg::BiasDepth];

    logic [conv3_pkg::SizeWidth-1:0]  r_image_size;
    logic [conv3_pkg::CinWidth-1:0]   r_channels_in;

    logic [2:0]                        r_state, n_state;
    logic [conv3_pkg::SizeWidth-1:0]   r_s, n_s;
    logic [3:0]                        r_oc, n_oc;
    logic [4:0]                        r_row, n_row;
    logic [4:0]                        r_col, n_col;
    logic [conv3_pkg::CinWidth-1:0]    r_cin, n_cin;
    logic                              r_oor, n_oor;
    logic [conv3_pkg::PlaneWidth-1:0]  r_plane, n_plane;
    logic [conv3_pkg::PidxWidth-1:0]   r_chstart, n_chstart;
    logic [conv3_pkg::PidxWidth-1:0]   r_rowstart, n_rowstart;
    logic [conv3_pkg::PidxWidth-1:0]   r_pidx, n_pidx;
    logic [conv3_pkg::WidxWidth-1:0]   r_widx, n_widx;
    logic [conv3_pkg::TapWidth-1:0]    r_tap, n_tap;
    logic [conv3_pkg::TapWidth-1:0]    r_last, n_last;
    logic [1:0]                        r_i, n_i;
    logic [1:0]                        r_j, n_j;
    logic signed [AW-1:0]              r_acc, n_acc;
    logic                              r_out_valid, n_out_valid;
    logic [conv3_pkg::QWidth-1:0]      r_conv_value, n_conv_value;
    logic [1:0]                        r_status, n_status;

    logic signed [DW-1:0]              r_pix_q, r_wt_q, r_bias_q;
    logic                              r_s1_vld, r_s1_pok, r_s1_wok;
    logic                              r_s2_vld;
    logic signed [2*DW-1:0]            r_prod;

    logic                              w_in_acc;
    logic [conv3_pkg::SizeWidth-1:0]   w_lim;
    logic                              w_oor;
    logic [conv3_pkg::CinWidth-1:0]    w_cin_sat;
    logic [7:0]                        w_oc_cin;
    logic [conv3_pkg::TapWidth-1:0]    w_taps;
    logic                              w_sat;
    logic                              w_out_free;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_conv_value = r_conv_value;
    assign o_status     = r_status;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_lim     = r_image_size - 6'd2;
    assign w_oor     = (r_image_size < conv3_pkg::KSize) ||
                       ({1'b0, i_out_row} >= w_lim) || ({1'b0, i_out_col} >= w_lim);
    assign w_cin_sat = (r_channels_in > conv3_pkg::MaxCin) ? conv3_pkg::MaxCin : r_channels_in;
    assign w_oc_cin  = 8'(r_oc) * 8'(r_cin);
    assign w_taps    = {r_cin[3:0], 3'b000} + {3'b000, r_cin};
    assign w_sat     = |r_acc[AW-2:23];
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_s          = r_s;
        n_oc         = r_oc;
        n_row        = r_row;
        n_col        = r_col;
        n_cin        = r_cin;
        n_oor        = r_oor;
        n_plane      = r_plane;
        n_chstart    = r_chstart;
        n_rowstart   = r_rowstart;
        n_pidx       = r_pidx;
        n_widx       = r_widx;
        n_tap        = r_tap;
        n_last       = r_last;
        n_i          = r_i;
        n_j          = r_j;
        n_acc        = r_acc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_conv_value = r_conv_value;
        n_status     = r_status;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_cmd == conv3_pkg::CMD_COMPUTE)) begin
                    n_s     = r_image_size;
                    n_oc    = i_out_channel;
                    n_row   = i_out_row;
                    n_col   = i_out_col;
                    n_cin   = w_cin_sat;
                    n_oor   = w_oor;
                    n_state = w_oor ? S_FINISH : S_SETUP;
                end
            end
            S_SETUP: begin
                n_plane    = conv3_pkg::PlaneWidth'(r_s) * conv3_pkg::PlaneWidth'(r_s);
                n_chstart  = conv3_pkg::PidxWidth'(r_row) * conv3_pkg::PidxWidth'(r_s) +
                             conv3_pkg::PidxWidth'(r_col);
                n_rowstart = n_chstart;
                n_pidx     = n_chstart;
                n_widx     = {w_oc_cin, 3'b000} + conv3_pkg::WidxWidth'(w_oc_cin);
                n_tap      = '0;
                n_last     = w_taps - 7'd1;
                n_i        = '0;
                n_j        = '0;
                n_state    = (r_cin == '0) ? S_DRAIN : S_RUN;
            end
            S_RUN: begin
                n_widx = r_widx + 11'd1;
                n_tap  = r_tap + 7'd1;
                if (r_j != 2'd2) begin
                    n_j    = r_j + 2'd1;
                    n_pidx = r_pidx + 15'd1;
                end else if (r_i != 2'd2) begin
                    n_j        = '0;
                    n_i        = r_i + 2'd1;
                    n_rowstart = r_rowstart + conv3_pkg::PidxWidth'(r_s);
                    n_pidx     = n_rowstart;
                end else begin
                    n_j        = '0;
                    n_i        = '0;
                    n_chstart  = r_chstart + conv3_pkg::PidxWidth'(r_plane);
                    n_rowstart = n_chstart;
                    n_pidx     = n_chstart;
                end
                if (r_tap == r_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!r_s1_vld && !r_s2_vld) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_oor) begin
                        n_conv_value = '0;
                        n_status     = conv3_pkg::STAT_RANGE;
                    end else if (r_acc[AW-1]) begin
                        n_conv_value = '0;
                        n_status     = conv3_pkg::STAT_OK;
                    end else if (w_sat) begin
                        n_conv_value = conv3_pkg::QMax;
                        n_status     = conv3_pkg::STAT_SAT;
                    end else begin
                        n_conv_value = r_acc[22:8];
                        n_status     = conv3_pkg::STAT_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_SETUP) begin
            n_acc = {{(AW-DW-8){r_bias_q[DW-1]}}, r_bias_q, 8'b0};
        end else if (r_s2_vld) begin
            n_acc = r_acc + {{(AW-2*DW){r_prod[2*DW-1]}}, r_prod};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_s1_vld      <= 1'b0;
            r_s2_vld      <= 1'b0;
            r_image_size  <= 6'd28;
            r_channels_in <= 4'd1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_s1_vld    <= (r_state == S_RUN);
            r_s2_vld    <= r_s1_vld;
            if (i_cfg_wr_en && (i_cfg_index == conv3_pkg::CFG_IMAGE_SIZE)) begin
                r_image_size <= i_cfg_data;
            end
            if (i_cfg_wr_en && (i_cfg_index == conv3_pkg::CFG_CHANNELS_IN)) begin
                r_channels_in <= i_cfg_data[conv3_pkg::CinWidth-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s          <= n_s;
        r_oc         <= n_oc;
        r_row        <= n_row;
        r_col        <= n_col;
        r_cin        <= n_cin;
        r_oor        <= n_oor;
        r_plane      <= n_plane;
        r_chstart    <= n_chstart;
        r_rowstart   <= n_rowstart;
        r_pidx       <= n_pidx;
        r_widx       <= n_widx;
        r_tap        <= n_tap;
        r_last       <= n_last;
        r_i          <= n_i;
        r_j          <= n_j;
        r_acc        <= n_acc;
        r_conv_value <= n_conv_value;
        r_status     <= n_status;
        r_s1_pok     <= (r_pidx[conv3_pkg::PidxWidth-1:conv3_pkg::PixAw] == '0);
        r_s1_wok     <= (r_widx[conv3_pkg::WidxWidth-1:conv3_pkg::WtAw] == '0);
        if (r_s1_pok && r_s1_wok) begin
            r_prod <= r_pix_q * r_wt_q;
        end else begin
            r_prod <= '0;
        end
    end

    // weight store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == conv3_pkg::CMD_WEIGHT) &&
            (i_addr[conv3_pkg::AddrWidth-1:conv3_pkg::WtAw] == '0)) begin
            wt_mem[i_addr[conv3_pkg::WtAw-1:0]] <= i_value;
        end
        r_wt_q <= wt_mem[r_widx[conv3_pkg::WtAw-1:0]];
    end

    // pixel store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == conv3_pkg::CMD_PIXEL)) begin
            pix_mem[i_addr[conv3_pkg::PixAw-1:0]] <= i_value;
        end
        r_pix_q <= pix_mem[r_pidx[conv3_pkg::PixAw-1:0]];
    end

    // bias store, read while idle so the word is ready in setup
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_cmd == conv3_pkg::CMD_BIAS) &&
            (i_addr[conv3_pkg::AddrWidth-1:conv3_pkg::BiasAw] == '0)) begin
            bias_mem[i_addr[conv3_pkg::BiasAw-1:0]] <= i_value;
        end
        if (r_state == S_IDLE) begin
            r_bias_q <= bias_mem[i_out_channel[conv3_pkg::BiasAw-1:0]];
        end
    end

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_vld && !r_s2_vld))
        else $error("MAC pipeline busy while idle");

    a_finish_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> (!r_s1_vld && !r_s2_vld))
        else $error("result formed before last product accumulated");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == conv3_pkg::STAT_RANGE)) |-> (o_conv_value == '0))
        else $error("out-of-range beat carries nonzero value");

    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == conv3_pkg::STAT_SAT)) |-> (o_conv_value == conv3_pkg::QMax))
        else $error("saturated beat not at max");

endmodule

// File: dv/tb_conv3x3_multichannel_relu_unit.sv
// Testbench for the 3x3 multichannel convolution unit: directed and random traffic, scoreboard.
`timescale 1ns / 100ps

module tb_conv3x3_multichannel_relu_unit;
    import conv3_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int IDLE_LIMIT  = 2000;
    localparam int SETTLE      = 100;

    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    localparam logic signed [DataWidth-1:0] Q_ONE  = 16'sh0100;
    localparam logic signed [DataWidth-1:0] Q_HIGH = 16'sh7fff;
    localparam logic signed [DataWidth-1:0] Q_LOW  = 16'sh8000;

    typedef struct packed {
        logic [QWidth-1:0] conv_value;
        logic [1:0]        status;
    } t_conv_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_wr_en;
    logic [1:0]                  i_cfg_index;
    logic [SizeWidth-1:0]        i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic [1:0]                  i_cmd;
    logic [AddrWidth-1:0]        i_addr;
    logic signed [DataWidth-1:0] i_value;
    logic [3:0]                  i_out_channel;
    logic [4:0]                  i_out_row;
    logic [4:0]                  i_out_col;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic [QWidth-1:0]           o_conv_value;
    logic [1:0]                  o_status;

    conv3x3_multichannel_relu_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_addr        (i_addr),
        .i_value       (i_value),
        .i_out_channel (i_out_channel),
        .i_out_row     (i_out_row),
        .i_out_col     (i_out_col),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_conv_value  (o_conv_value),
        .o_status      (o_status)
    );

    // shadow of the block's registers and stores
    logic [SizeWidth-1:0]        img_size;
    logic [CinWidth-1:0]         ch_cfg;
    logic signed [DataWidth-1:0] pix_mem  [PixelDepth];
    logic signed [DataWidth-1:0] wt_mem   [WeightDepth];
    logic signed [DataWidth-1:0] bias_mem [BiasDepth];
    bit                          pix_written  [PixelDepth];
    bit                          wt_written   [WeightDepth];
    bit                          bias_written [BiasDepth];

    t_conv_result conv_expected[$];
    int           errors;
    int           items_sent;
    int           conv_requests;
    int           idle_cycles;
    int           stall_left;
    bit           quiet;
    int           val_mode;

    logic [1:0] write_cmds [3] = '{CMD_WEIGHT, CMD_BIAS, CMD_PIXEL};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int eff_cin();
        return (ch_cfg > MaxCin) ? int'(MaxCin) : int'(ch_cfg);
    endfunction

    function automatic bit window_in_range(input int row, input int col);
        int s;
        s = img_size;
        return (s >= 3) && (row < s - 2) && (col < s - 2);
    endfunction

    function automatic t_conv_result predict_conv(input int oc, input int row, input int col);
        t_conv_result res;
        longint       acc;
        int           s, cin, ch, i, j, p, w;
        s   = img_size;
        cin = eff_cin();
        acc = 0;
        res.conv_value = '0;
        res.status     = STAT_OK;
        if (!window_in_range(row, col)) begin
            res.status = STAT_RANGE;
            return res;
        end
        for (ch = 0; ch < cin; ch++) begin
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    p = ch * s * s + (row + i) * s + col + j;
                    w = oc * cin * 9 + ch * 9 + i * 3 + j;
                    if (p < PixelDepth && w < WeightDepth) begin
                        acc += longint'(wt_mem[w]) * longint'(pix_mem[p]);
                    end
                end
            end
        end
        if (oc < BiasDepth) begin
            acc += longint'(bias_mem[oc]) * 256;
        end
        if (acc >= 0) begin
            if ((acc >>> 8) > longint'(QMax)) begin
                res.conv_value = QMax;
                res.status     = STAT_SAT;
            end else begin
                res.conv_value = acc[22:8];
            end
        end
        return res;
    endfunction

    function automatic logic signed [DataWidth-1:0] rand_word();
        if ($urandom_range(99) < 6) begin
            case ($urandom_range(3))
                0: return Q_HIGH;
                1: return Q_LOW;
                2: return '0;
                default: return '1;
            endcase
        end
        case (val_mode)
            0: return DataWidth'($urandom);
            1: return DataWidth'(int'($urandom_range(1023)) - 512);
            default: return DataWidth'($urandom_range(200));
        endcase
    endfunction

    // one beat on the input channel; valid stays up if the next beat follows at once
    task automatic send_beat(input logic [1:0] cmd, input logic [AddrWidth-1:0] addr,
                             input logic signed [DataWidth-1:0] value, input logic [3:0] oc,
                             input logic [4:0] row, input logic [4:0] col);
        int gap;
        gap = (!quiet && $urandom_range(99) < 8) ? $urandom_range(1, 2) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_addr        <= addr;
        i_value       <= value;
        i_out_channel <= oc;
        i_out_row     <= row;
        i_out_col     <= col;
        do @(posedge i_clk); while (!o_in_ready);
        case (cmd)
            CMD_WEIGHT: begin
                if (addr < WeightDepth) begin
                    wt_mem[addr]     = value;
                    wt_written[addr] = 1'b1;
                    items_sent++;
                end
            end
            CMD_BIAS: begin
                if (addr < BiasDepth) begin
                    bias_mem[addr]     = value;
                    bias_written[addr] = 1'b1;
                    items_sent++;
                end
            end
            CMD_PIXEL: begin
                pix_mem[addr]     = value;
                pix_written[addr] = 1'b1;
                items_sent++;
            end
            default: begin
                conv_expected.push_back(predict_conv(oc, row, col));
                items_sent++;
                conv_requests++;
            end
        endcase
    endtask

    task automatic write_word(input logic [1:0] cmd, input int addr,
                              input logic signed [DataWidth-1:0] value);
        send_beat(cmd, AddrWidth'(addr), value, 4'($urandom), 5'($urandom), 5'($urandom));
    endtask

    task automatic request_conv(input int oc, input int row, input int col);
        send_beat(CMD_COMPUTE, AddrWidth'($urandom), DataWidth'($urandom), 4'(oc), 5'(row),
                  5'(col));
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (conv_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [SizeWidth-1:0] data);
        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            CFG_IMAGE_SIZE:  img_size = data;
            CFG_CHANNELS_IN: ch_cfg   = data[CinWidth-1:0];
            default: ;
        endcase
    endtask

    // write every store entry a request will read that has not been written yet
    task automatic load_window(input int oc, input int row, input int col);
        int s, cin, ch, i, j, p, w;
        s   = img_size;
        cin = eff_cin();
        if (!window_in_range(row, col)) return;
        for (ch = 0; ch < cin; ch++) begin
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    p = ch * s * s + (row + i) * s + col + j;
                    w = oc * cin * 9 + ch * 9 + i * 3 + j;
                    if (p < PixelDepth && !pix_written[p]) write_word(CMD_PIXEL, p, rand_word());
                    if (w < WeightDepth && !wt_written[w]) write_word(CMD_WEIGHT, w, rand_word());
                end
            end
        end
        if (oc < BiasDepth && !bias_written[oc]) write_word(CMD_BIAS, oc, rand_word());
    endtask

    task automatic refresh_window(input int oc, input int row, input int col);
        int s, cin, p, w;
        s   = img_size;
        cin = eff_cin();
        p   = 0;
        w   = 0;
        if (cin > 0) begin
            p = $urandom_range(cin - 1);
            w = oc * cin * 9 + p * 9;
            p = p * s * s;
        end
        p += (row + $urandom_range(2)) * s + col + $urandom_range(2);
        w += $urandom_range(8);
        case ($urandom_range(2))
            0: if (cin > 0 && p < PixelDepth) write_word(CMD_PIXEL, p, rand_word());
            1: if (cin > 0 && w < WeightDepth) write_word(CMD_WEIGHT, w, rand_word());
            default: if (oc < BiasDepth) write_word(CMD_BIAS, oc, rand_word());
        endcase
    endtask

    task automatic test_config_spare_index();
        cfg_write(CFG_IMAGE_SIZE, 6'd3);
        cfg_write(CFG_CHANNELS_IN, 6'd1);
        cfg_write(CFG_SPARE_LO, 6'd0);
        cfg_write(CFG_SPARE_HI, 6'd0);
    endtask

    task automatic test_base_window();
        int k;
        for (k = 0; k < 9; k++) write_word(CMD_WEIGHT, k, Q_ONE);
        for (k = 0; k < 9; k++) begin
            write_word(CMD_PIXEL, k,
                       (k == 0) ? Q_LOW : (k == 8) ? Q_HIGH : DataWidth'(16'sh0041 + k));
        end
        write_word(CMD_BIAS, 0, '0);
        request_conv(0, 0, 0);
        request_conv(0, 0, 1);
        request_conv(0, 31, 31);
    endtask

    task automatic test_ignored_writes();
        write_word(CMD_WEIGHT, WeightDepth, Q_HIGH);
        write_word(CMD_WEIGHT, 2047, Q_LOW);
        write_word(CMD_BIAS, BiasDepth, Q_HIGH);
        write_word(CMD_BIAS, 2047, Q_LOW);
        request_conv(0, 0, 0);
    endtask

    task automatic test_bias_extremes();
        write_word(CMD_BIAS, 0, Q_HIGH);
        request_conv(0, 0, 0);
        write_word(CMD_BIAS, 0, Q_LOW);
        request_conv(0, 0, 0);
    endtask

    task automatic test_no_channels();
        cfg_write(CFG_CHANNELS_IN, 6'd0);
        request_conv(0, 0, 0);
        write_word(CMD_BIAS, 0, 16'sh1234);
        request_conv(0, 0, 0);
    endtask

    task automatic test_tiny_image();
        cfg_write(CFG_IMAGE_SIZE, 6'd2);
        request_conv(0, 0, 0);
        cfg_write(CFG_IMAGE_SIZE, 6'd0);
        request_conv(0, 0, 0);
    endtask

    // channel count above eight, reads past the pixel and weight stores
    task automatic test_oversized_image();
        cfg_write(CFG_IMAGE_SIZE, 6'd63);
        cfg_write(CFG_CHANNELS_IN, 6'd12);
        load_window(15, 0, 0);
        request_conv(15, 0, 0);
    endtask

    task automatic random_op(input int oc_a, input int oc_b);
        int pick, s, oc, row, col, lim;
        pick = $urandom_range(99);
        s    = img_size;
        if (pick < 18) begin
            oc = $urandom_range(2);
            if ($urandom_range(1) == 0) begin
                write_word(write_cmds[oc], $urandom_range(2047), rand_word());
            end else begin
                write_word(write_cmds[oc], $urandom_range(15), rand_word());
            end
        end else if (pick < 28) begin
            if (s < 33) begin
                row = $urandom_range(31);
                col = (s < 3) ? $urandom_range(31) : $urandom_range(31, s - 2);
                if ($urandom_range(1) == 0) request_conv($urandom_range(15), row, col);
                else request_conv($urandom_range(15), col, row);
            end
        end else if (pick < 31) begin
            drain_results();
        end else begin
            oc = ($urandom_range(9) == 0) ? $urandom_range(15) :
                 ($urandom_range(1) == 0) ? oc_a : oc_b;
            if (s < 3) begin
                request_conv(oc, $urandom_range(31), $urandom_range(31));
            end else begin
                lim = (s - 3 > 31) ? 31 : s - 3;
                if ($urandom_range(7) == 0) begin
                    row = $urandom_range(lim);
                    col = $urandom_range(lim);
                end else begin
                    row = $urandom_range((lim > 4) ? 4 : lim);
                    col = $urandom_range((lim > 4) ? 4 : lim);
                end
                load_window(oc, row, col);
                repeat ($urandom_range(2)) refresh_window(oc, row, col);
                request_conv(oc, row, col);
            end
        end
    endtask

    task automatic test_random_traffic();
        int phase_size [6] = '{32, 3, 28, 16, 1, 45};
        int phase_cin  [6] = '{8, 1, 0, 15, 4, 9};
        int phase, s, cin, start, oc_a, oc_b;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase < 6) begin
                s   = phase_size[phase];
                cin = phase_cin[phase];
            end else if ($urandom_range(5) == 0) begin
                s   = $urandom_range(63);
                cin = $urandom_range(15);
            end else begin
                s   = $urandom_range(3, 32);
                cin = $urandom_range(1, 8);
            end
            cfg_write(CFG_IMAGE_SIZE, SizeWidth'(s));
            cfg_write(CFG_CHANNELS_IN, {2'($urandom), 4'(cin)});
            quiet    = (phase == 3);
            val_mode = phase % 3;
            oc_a     = $urandom_range(15);
            oc_b     = $urandom_range(15);
            start    = conv_requests;
            while (conv_requests - start < 12 && items_sent < ITEM_TARGET) begin
                random_op(oc_a, oc_b);
            end
            phase++;
        end
        quiet = 1'b0;
    endtask

    // scoreboard
    always @(posedge i_clk) begin
        t_conv_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (conv_expected.size() == 0) begin
                $error("result beat with none pending: conv_value %0d status %0d",
                       o_conv_value, o_status);
                errors++;
            end else begin
                want = conv_expected.pop_front();
                if (o_conv_value !== want.conv_value) begin
                    $error("conv_value: expected %0d, got %0d", want.conv_value, o_conv_value);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (!quiet && $urandom_range(99) < 4) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = CFG_IMAGE_SIZE;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_WEIGHT;
        i_addr        = '0;
        i_value       = '0;
        i_out_channel = '0;
        i_out_row     = '0;
        i_out_col     = '0;
        img_size      = 6'd28;
        ch_cfg        = 4'd1;
        val_mode      = 1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_config_spare_index();
        test_base_window();
        test_ignored_writes();
        test_bias_extremes();
        test_no_channels();
        test_tiny_image();
        test_oversized_image();
        test_random_traffic();

        drain_results();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: conv3x3_multichannel_relu_unit.f
rtl/conv3_pkg.sv
rtl/conv3x3_multichannel_relu_unit.sv
dv/tb_conv3x3_multichannel_relu_unit.sv
